### src/lie_pkg.sv
// Package for the terminal line editor: key codes, echo characters,
// result kinds, register indexes and store sizes.
// Used by line_input_editor; depends on nothing.
package lie_pkg;

  // Line store size and the widths that follow from it.
  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = 6;
  localparam int COUNT_W  = 8;
  localparam int BYTE_W   = 8;
  localparam int CFG_W    = 6;
  localparam int IDX_W    = 1;
  localparam int KIND_W   = 2;
  localparam int TDATA_W  = 16;

  // Received key codes.
  localparam logic [BYTE_W-1:0] KEY_ENTER  = 8'd13;
  localparam logic [BYTE_W-1:0] KEY_DELETE = 8'd127;

  // Echo characters.
  localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'd42;
  localparam logic [BYTE_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MAX_LENGTH = 1'b0;
  localparam logic [IDX_W-1:0] REG_MASK_ECHO  = 1'b1;

  // Saturation value of the typed count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

endpackage

### src/line_input_editor.sv
// Terminal line editor with echo: edits received bytes into a line held
// in a synchronous memory and replays the line on Enter.
// Depends on lie_pkg.
//
// A plain byte is echoed in the cycle after it is accepted; one byte per
// cycle is sustained when the output side never stalls. Delete of a typed
// byte gives three echo words (backspace, space, backspace), Delete on an
// empty line none. Enter on an empty line gives only the end record; else
// each stored byte is read in S_READ and sent in S_SEND, then the end record.
// Reset clears the typed count and restores max_length to 32 and
// mask_echo to 0; the line store holds no reset value.
module line_input_editor (
  input  logic                         clk,
  input  logic                         rst,
  // Input stream. s_tdata: rx_byte[7:0].
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lie_pkg::BYTE_W-1:0]   s_tdata,
  // Output stream. m_tdata: out_byte[7:0], line_length[13:8],
  // overflow[14], zero[15]. m_tuser: kind[1:0].
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lie_pkg::TDATA_W-1:0]  m_tdata,
  output logic [lie_pkg::KIND_W-1:0]   m_tuser,
  output logic                         m_tlast,
  // Configuration write port.
  input  logic                         cfg_we,
  input  logic [lie_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lie_pkg::CFG_W-1:0]    cfg_data
);
  import lie_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEL  = 5'b00010,
    S_READ = 5'b00100,
    S_SEND = 5'b01000,
    S_END  = 5'b10000
  } state_t;

  // Control and configuration registers.
  state_t             state, state_next;
  logic [COUNT_W-1:0] typed_count, typed_count_next;
  logic [LEN_W-1:0]   max_length;
  logic               mask_echo;
  logic               del_step, del_step_next;
  logic [ADDR_W-1:0]  rd_idx, rd_idx_next;
  logic [LEN_W-1:0]   line_len, line_len_next;
  logic               line_ovf, line_ovf_next;

  // Line store.
  logic [BYTE_W-1:0]  line_store [CAPACITY];
  logic [BYTE_W-1:0]  rd_data;
  logic               mem_we;

  // Output word register.
  logic               emit;
  logic [KIND_W-1:0]  emit_kind;
  logic [BYTE_W-1:0]  emit_byte;
  logic [LEN_W-1:0]   emit_len;
  logic               emit_ovf;
  logic               emit_last;
  logic [BYTE_W-1:0]  out_byte;
  logic [LEN_W-1:0]   out_len;
  logic               out_ovf;

  logic               out_free;
  logic               accept;
  logic [LEN_W-1:0]   lim;
  logic [LEN_W-1:0]   cur_len;
  logic               is_enter;
  logic               is_delete;
  logic               below_lim;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign is_enter  = (s_tdata == KEY_ENTER);
  assign is_delete = (s_tdata == KEY_DELETE);

  // Effective limit is max_length clamped to the store capacity.
  assign lim = (max_length > LEN_W'(CAPACITY)) ? LEN_W'(CAPACITY) : max_length;
  assign below_lim = (typed_count < COUNT_W'(lim));
  assign cur_len   = below_lim ? typed_count[LEN_W-1:0] : lim;
  assign mem_we    = accept && !is_enter && !is_delete && below_lim;

  // Next-state and result selection.
  always_comb begin
    state_next       = state;
    typed_count_next = typed_count;
    del_step_next    = del_step;
    rd_idx_next      = rd_idx;
    line_len_next    = line_len;
    line_ovf_next    = line_ovf;
    emit      = 1'b0;
    emit_kind = KIND_ECHO;
    emit_byte = '0;
    emit_len  = '0;
    emit_ovf  = 1'b0;
    emit_last = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_enter) begin
            line_len_next    = cur_len;
            line_ovf_next    = (typed_count > COUNT_W'(lim));
            typed_count_next = '0;
            rd_idx_next      = '0;
            if (cur_len == '0) begin
              // Empty line: only the end record.
              emit      = 1'b1;
              emit_kind = KIND_END;
              emit_ovf  = (typed_count > COUNT_W'(lim));
              emit_last = 1'b1;
            end else begin
              state_next = S_READ;
            end
          end else if (is_delete) begin
            if (typed_count != '0) begin
              emit             = 1'b1;
              emit_byte        = CHAR_BS;
              typed_count_next = typed_count - 1'b1;
              del_step_next    = 1'b0;
              state_next       = S_DEL;
            end
          end else begin
            emit      = 1'b1;
            emit_byte = mask_echo ? CHAR_STAR : s_tdata;
            emit_last = 1'b1;
            if (typed_count != COUNT_MAX) begin
              typed_count_next = typed_count + 1'b1;
            end
          end
        end
      end
      S_DEL: begin
        // Space, then the closing backspace.
        if (out_free) begin
          emit = 1'b1;
          if (!del_step) begin
            emit_byte     = CHAR_SPACE;
            del_step_next = 1'b1;
          end else begin
            emit_byte  = CHAR_BS;
            emit_last  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_READ: begin
        // Memory read issued this cycle; data is valid in S_SEND.
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_LINE;
          emit_byte = rd_data;
          rd_idx_next = rd_idx + 1'b1;
          if ({1'b0, rd_idx} + 1'b1 == line_len) begin
            state_next = S_END;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_END;
          emit_len   = line_len;
          emit_ovf   = line_ovf;
          emit_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      typed_count <= '0;
      max_length  <= LEN_W'(CAPACITY);
      mask_echo   <= 1'b0;
      del_step    <= 1'b0;
      rd_idx      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      typed_count <= typed_count_next;
      del_step    <= del_step_next;
      rd_idx      <= rd_idx_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_LENGTH: max_length <= cfg_data;
          REG_MASK_ECHO:  mask_echo  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    line_len <= line_len_next;
    line_ovf <= line_ovf_next;
    if (emit) begin
      m_tuser  <= emit_kind;
      out_byte <= emit_byte;
      out_len  <= emit_len;
      out_ovf  <= emit_ovf;
      m_tlast  <= emit_last;
    end
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[typed_count[ADDR_W-1:0]] <= s_tdata;
    end
    if (state == S_READ) begin
      rd_data <= line_store[rd_idx];
    end
  end

  assign m_tdata = {1'b0, out_ovf, out_len, out_byte};

endmodule

### sim/line_input_editor_tb.sv
`timescale 1ns / 1ps
// Testbench for line_input_editor: drives terminal bytes with bursty gaps, stalls the
// output side, and checks every output word against a line editor predictor.
// Depends on lie_pkg and line_input_editor.
module line_input_editor_tb;
  import lie_pkg::*;

  // One output word as the predictor sees it.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  line_length;
    logic              overflow;
    logic              last;
  } editor_word_t;

  // Line editor predictor and scoreboard of expected output words.
  class line_scoreboard;
    logic [BYTE_W-1:0]  line_mem [CAPACITY];
    logic [COUNT_W-1:0] typed;
    logic [CFG_W-1:0]   max_len;
    logic               mask_on;
    editor_word_t       expected_q [$];
    int                 errors;
    int                 words_seen;
    int                 lines_seen;
    bit                 saw_saturation;

    function new();
      typed          = '0;
      max_len        = 6'd32;
      mask_on        = 1'b0;
      errors         = 0;
      words_seen     = 0;
      lines_seen     = 0;
      saw_saturation = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_MAX_LENGTH) max_len = val;
      else mask_on = val[0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_word(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b,
                            logic [LEN_W-1:0] len, logic ovf, logic lst);
      editor_word_t w;
      w.kind        = k;
      w.out_byte    = b;
      w.line_length = len;
      w.overflow    = ovf;
      w.last        = lst;
      expected_q.push_back(w);
    endfunction

    // Works out the words that one accepted byte causes and updates the line state.
    function void note_byte(logic [BYTE_W-1:0] c);
      int lim;
      int len;
      lim = (max_len > CAPACITY) ? CAPACITY : int'(max_len);
      if (c == KEY_ENTER) begin
        len = (typed < lim) ? int'(typed) : lim;
        for (int i = 0; i < len; i++)
          push_word(KIND_LINE, line_mem[i[ADDR_W-1:0]], '0, 1'b0, 1'b0);
        push_word(KIND_END, '0, LEN_W'(len), typed > lim, 1'b1);
        typed = '0;
        lines_seen++;
      end else if (c == KEY_DELETE) begin
        if (typed != 0) begin
          push_word(KIND_ECHO, CHAR_BS, '0, 1'b0, 1'b0);
          push_word(KIND_ECHO, CHAR_SPACE, '0, 1'b0, 1'b0);
          push_word(KIND_ECHO, CHAR_BS, '0, 1'b0, 1'b1);
          typed = typed - 1'b1;
        end
      end else begin
        push_word(KIND_ECHO, mask_on ? CHAR_STAR : c, '0, 1'b0, 1'b1);
        if (typed < lim && typed < CAPACITY) line_mem[typed[ADDR_W-1:0]] = c;
        if (typed != COUNT_MAX) typed = typed + 1'b1;
        else saw_saturation = 1;
      end
    endfunction

    // Compares one accepted output word with the oldest expectation.
    function void check_word(logic [KIND_W-1:0] k, logic [TDATA_W-1:0] data, logic lst);
      editor_word_t w;
      words_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected word kind %0d data %h last %b", $time, k, data, lst);
        return;
      end
      w = expected_q.pop_front();
      if (k !== w.kind || data[7:0] !== w.out_byte || data[13:8] !== w.line_length ||
          data[14] !== w.overflow || data[15] !== 1'b0 || lst !== w.last) begin
        errors++;
        if (errors <= 20)
          $display({"%0t: word mismatch expected kind %0d byte %h len %0d ovf %b last %b,",
                    " actual kind %0d byte %h len %0d ovf %b pad %b last %b"},
                   $time, w.kind, w.out_byte, w.line_length, w.overflow, w.last,
                   k, data[7:0], data[13:8], data[14], data[15], lst);
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic [KIND_W-1:0]    m_tuser;
  logic                 m_tlast;
  logic                 cfg_we    = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  line_scoreboard sb;
  int  burst_left = 0;
  int  gap_max    = 4;
  bit  stall_on   = 1'b1;
  int  ready_cnt  = 0;
  int  n_sent     = 0;

  line_input_editor i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Output side: check each accepted word, then stall in random runs.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready)
      sb.check_word(m_tuser, m_tdata, m_tlast);
    if (ready_cnt == 0) begin
      if (m_tready && stall_on) begin
        m_tready  <= 1'b0;
        ready_cnt <= $urandom_range(1, 5);
      end else begin
        m_tready  <= 1'b1;
        ready_cnt <= $urandom_range(1, 12);
      end
    end else begin
      ready_cnt <= ready_cnt - 1;
    end
  end

  // Sends one word, opening a new burst after a random gap when the last one ran out.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_byte(b);
    n_sent++;
  endtask

  // Waits until every expected word has come, then lets the block settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Writes one configuration register; the block must be idle.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // A plain byte: anything but Enter or Delete.
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == KEY_ENTER || b == KEY_DELETE);
    return b;
  endfunction

  // Types a line of n keys with occasional Delete, then Enter.
  task automatic type_line(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15) send_byte(KEY_DELETE);
      else send_byte(plain_byte());
    end
    send_byte(KEY_ENTER);
  endtask

  // Main sequence.
  initial begin
    int phase_items;
    logic [CFG_W-1:0] len_choice;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty line cases and extreme byte values with reset settings.
    send_byte(KEY_ENTER);
    send_byte(KEY_DELETE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7E);
    send_byte(8'h0C);
    send_byte(8'h0E);
    send_byte(KEY_DELETE);
    send_byte(KEY_ENTER);
    wait_idle();

    // Directed: short limit with masking, overflow, then Delete of an extra byte.
    write_reg(REG_MAX_LENGTH, 6'd2);
    write_reg(REG_MASK_ECHO, 6'd1);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    send_byte(KEY_DELETE);
    send_byte(8'h64);
    send_byte(KEY_ENTER);
    wait_idle();

    // Directed: zero limit stores nothing; then a limit above capacity.
    write_reg(REG_MAX_LENGTH, 6'd0);
    send_byte(8'h78);
    send_byte(KEY_ENTER);
    wait_idle();
    write_reg(REG_MAX_LENGTH, 6'd63);
    write_reg(REG_MASK_ECHO, 6'd0);
    send_byte(8'h41);
    send_byte(KEY_ENTER);
    wait_idle();

    // Random phases over several settings; each phase ends on a line boundary.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: len_choice = 6'd32;
        1: len_choice = 6'd1;
        2: len_choice = 6'd63;
        3: len_choice = 6'd0;
        4: len_choice = 6'd31;
        default: len_choice = CFG_W'($urandom_range(0, 63));
      endcase
      write_reg(REG_MAX_LENGTH, len_choice);
      write_reg(REG_MASK_ECHO, CFG_W'(ph % 2));
      stall_on = (ph != 2);
      gap_max  = (ph == 2) ? 0 : $urandom_range(1, 6);
      phase_items = 0;
      while (phase_items < 15) begin
        if ($urandom_range(0, 3) == 0) begin
          // Noise: any byte at all, then close the line.
          for (int i = 0; i < 4; i++) begin
            send_byte(8'($urandom_range(0, 255)));
            phase_items++;
          end
          send_byte(KEY_ENTER);
          phase_items++;
        end else begin
          int n;
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 10);
          type_line(n);
          phase_items += n + 1;
        end
      end
      wait_idle();
    end

    // Saturated count: type past 255, delete a few, then end the line.
    write_reg(REG_MAX_LENGTH, 6'd4);
    gap_max  = 2;
    stall_on = 1'b1;
    for (int i = 0; i < 258; i++) send_byte(plain_byte());
    for (int i = 0; i < 3; i++) send_byte(KEY_DELETE);
    send_byte(KEY_ENTER);
    wait_idle();

    $display("Sent %0d words, checked %0d output words over %0d lines;", n_sent,
             sb.words_seen, sb.lines_seen);
    $display("limits 0 to 63, masked and plain echo, saturated count %0s.",
             sb.saw_saturation ? "reached" : "not reached");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
